// ----- rtl/core/skbh_pkg.sv -----
// types, constants and hash functions shared by the bucket hash block
`default_nettype none
package skbh_pkg;

    localparam int unsigned HASH_W     = 32;
    localparam int unsigned BUCKET_W   = 24;
    localparam int unsigned BITS_W     = 5;
    localparam int unsigned MIX_STAGES = 4;

    localparam logic [HASH_W-1:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [HASH_W-1:0] GOLDEN_MULT = 32'd2654435761;
    localparam logic [BITS_W-1:0] BITS_MIN    = 5'd8;
    localparam logic [BITS_W-1:0] BITS_MAX    = 5'd24;
    localparam logic [BITS_W-1:0] BITS_RESET  = 5'd8;

    // control handed from the byte front end to the hash pipeline
    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctrl_t;

    // one byte of reflected crc-32, eight bit steps
    function automatic logic [HASH_W-1:0] crc_byte(input logic [HASH_W-1:0] crc,
                                                   input logic [7:0] data);
        logic [HASH_W-1:0] c;
        begin
            c = crc ^ {24'd0, data};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            return c;
        end
    endfunction

    // one add/xor pair of the integer mix
    function automatic logic [HASH_W-1:0] mix_step(input logic [HASH_W-1:0] h,
                                                   input logic [1:0] step);
        logic [HASH_W-1:0] a;
        begin
            unique case (step)
                2'd0: begin
                    a = h + (h << 12);
                    a = a ^ (a >> 22);
                end
                2'd1: begin
                    a = h + (h << 4);
                    a = a ^ (a >> 9);
                end
                2'd2: begin
                    a = h + (h << 10);
                    a = a ^ (a >> 2);
                end
                default: begin
                    a = h + (h << 7);
                    a = a ^ (a >> 12);
                end
            endcase
            return a;
        end
    endfunction

    // table size limited to the supported range
    function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] bits);
        begin
            if (bits < BITS_MIN) begin
                return BITS_MIN;
            end else if (bits > BITS_MAX) begin
                return BITS_MAX;
            end
            return bits;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/skbh_hash_pipe.sv -----
// mix, multiply and bucket reduction pipeline with output register
`default_nettype none
module skbh_hash_pipe (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire skbh_pkg::pipe_ctrl_t          ctrl,
    input  wire logic [skbh_pkg::HASH_W-1:0]   crc_in,
    input  wire logic [skbh_pkg::BITS_W-1:0]   bucket_bits,
    output logic                               out_valid,
    output logic [skbh_pkg::BUCKET_W-1:0]      out_bucket,
    output logic [skbh_pkg::HASH_W-1:0]        out_hash
);
    import skbh_pkg::*;

    logic [HASH_W-1:0]   h_reg [0:MIX_STAGES];
    logic                h_valid_reg [0:MIX_STAGES];
    logic [HASH_W-1:0]   prod_reg;
    logic                prod_valid_reg;
    logic [BUCKET_W-1:0] bucket_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic                out_valid_reg;

    logic [HASH_W-1:0]   shifted;
    logic [BITS_W-1:0]   bits_eff;
    logic [BUCKET_W:0]   mask_wide;
    logic [BUCKET_W-1:0] bucket_next;

    // shift before the golden-ratio multiply
    assign shifted = h_reg[MIX_STAGES] >> 3;

    // bucket mask from the clamped table size
    always_comb begin
        bits_eff    = clamp_bits(bucket_bits);
        mask_wide   = ((BUCKET_W+1)'(1) << bits_eff) - (BUCKET_W+1)'(1);
        bucket_next = prod_reg[BUCKET_W-1:0] & mask_wide[BUCKET_W-1:0];
    end

    // valid bits of every stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= MIX_STAGES; i++) begin
                h_valid_reg[i] <= 1'b0;
            end
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (ctrl.advance) begin
            h_valid_reg[0] <= ctrl.valid;
            for (int i = 1; i <= MIX_STAGES; i++) begin
                h_valid_reg[i] <= h_valid_reg[i-1];
            end
            prod_valid_reg <= h_valid_reg[MIX_STAGES];
            out_valid_reg  <= prod_valid_reg;
        end
    end

    // payload: one mix pair per stage, then multiply, then mask
    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            h_reg[0] <= crc_in;
            for (int i = 1; i <= MIX_STAGES; i++) begin
                h_reg[i] <= mix_step(h_reg[i-1], 2'(i-1));
            end
            prod_reg   <= shifted * GOLDEN_MULT;
            bucket_reg <= bucket_next;
            hash_reg   <= prod_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_bucket = bucket_reg;
    assign out_hash   = hash_reg;

endmodule
`default_nettype wire

// ----- rtl/core/string_key_bucket_hash_top.sv -----
// top level of the string key bucket hash block
`default_nettype none
// Hashes a key that arrives one byte per item: a reflected CRC-32 (start 0, no
// final inversion) runs over the valid bytes, and an item with s_last_byte set
// sends the CRC through the integer shift/add/xor mix, a shift right by 3 and a
// multiply by 2654435761, giving m_mixed_hash and m_bucket_index (its low
// bucket_bits bits, bucket_bits clamped to 8..24). The CRC restarts at zero after
// every last item. One item is taken per cycle unless the pipeline stalls; after
// its last item is accepted, a result passes one capture stage, four mix stages,
// one multiply stage, then the output register. The whole pipeline stalls only
// while a result waits in the output register. cfg_data sets bucket_bits and is
// always ready; write it only while no key is in flight.
module string_key_bucket_hash_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [skbh_pkg::BITS_W-1:0]       cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_key_byte,
    input  wire logic                              s_byte_valid,
    input  wire logic                              s_last_byte,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [skbh_pkg::BUCKET_W-1:0]          m_bucket_index,
    output logic [skbh_pkg::HASH_W-1:0]            m_mixed_hash
);
    import skbh_pkg::*;

    logic [HASH_W-1:0] crc_reg;
    logic [HASH_W-1:0] crc_next;
    logic [HASH_W-1:0] crc_upd;
    logic [BITS_W-1:0] bits_reg;
    logic              advance;
    logic              s_accept;
    pipe_ctrl_t        ctrl;

    // pipeline moves whenever the output register is free or being drained
    assign advance   = !m_valid || m_ready;
    assign s_ready   = advance;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // running crc update
    always_comb begin
        crc_upd  = s_byte_valid ? crc_byte(crc_reg, s_key_byte) : crc_reg;
        crc_next = crc_reg;
        if (s_accept) begin
            crc_next = s_last_byte ? '0 : crc_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
        end else begin
            crc_reg <= crc_next;
        end
    end

    // table size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg <= BITS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            bits_reg <= cfg_data;
        end
    end

    assign ctrl.advance = advance;
    assign ctrl.valid   = s_accept && s_last_byte;

    skbh_hash_pipe u_hash_pipe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .crc_in      (crc_upd),
        .bucket_bits (bits_reg),
        .out_valid   (m_valid),
        .out_bucket  (m_bucket_index),
        .out_hash    (m_mixed_hash)
    );

`ifndef SYNTHESIS
    // the crc restarts after every key
    a_crc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_byte |=> crc_reg == '0)
        else $error("crc not cleared after last item");

    // an idle item leaves the crc alone
    a_idle_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_byte_valid && !s_last_byte |=> $stable(crc_reg))
        else $error("idle item changed the crc");

    // the bucket is always a masked copy of the hash
    a_bucket_sub: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bucket_index & ~m_mixed_hash[BUCKET_W-1:0]) == '0)
        else $error("bucket index not taken from the hash");

    // the low eight bits always survive the mask
    a_bucket_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_bucket_index[7:0] == m_mixed_hash[7:0])
        else $error("bucket index lost low bits");
`endif

endmodule
`default_nettype wire
